/* hw/rtl/atatf_pkg.sv */
package atatf_pkg;

    // one request word
    typedef struct packed {
        logic        kind;
        logic        is_write;
        logic [47:0] start_sector;
        logic [15:0] sector_count;
    } cmd_word_t;

    // one task-file register write
    typedef struct packed {
        logic [3:0] reg_select;
        logic [7:0] reg_value;
        logic       last;
    } tf_word_t;

    // decoded command held in the queue between front and back
    typedef struct packed {
        logic        flush;
        logic        lba48;
        logic [7:0]  devsel;
        logic [15:0] count;
        logic [47:0] lba_bytes;
        logic [7:0]  opcode;
    } cmd_entry_t;

    typedef enum logic [1:0] {
        MODE_CHS   = 2'd0,
        MODE_LBA28 = 2'd1,
        MODE_LBA48 = 2'd2
    } addr_mode_t;

    // configuration register indexes
    localparam logic [1:0] CFG_LBA_SUPPORTED   = 2'd0;
    localparam logic [1:0] CFG_DEVICE_SLAVE    = 2'd1;
    localparam logic [1:0] CFG_LBA48_THRESHOLD = 2'd2;

    // task-file register selects
    localparam logic [3:0] SEL_DEVSEL   = 4'd0;
    localparam logic [3:0] SEL_COUNT_HI = 4'd1;
    localparam logic [3:0] SEL_LBA3     = 4'd2;
    localparam logic [3:0] SEL_LBA4     = 4'd3;
    localparam logic [3:0] SEL_LBA5     = 4'd4;
    localparam logic [3:0] SEL_COUNT_LO = 4'd5;
    localparam logic [3:0] SEL_LBA0     = 4'd6;
    localparam logic [3:0] SEL_LBA1     = 4'd7;
    localparam logic [3:0] SEL_LBA2     = 4'd8;
    localparam logic [3:0] SEL_CMD      = 4'd9;

    // opcodes
    localparam logic [7:0] OP_READ      = 8'h20;
    localparam logic [7:0] OP_READ_EXT  = 8'h24;
    localparam logic [7:0] OP_WRITE     = 8'h30;
    localparam logic [7:0] OP_WRITE_EXT = 8'h34;
    localparam logic [7:0] OP_FLUSH     = 8'hE7;
    localparam logic [7:0] OP_FLUSH_EXT = 8'hEA;

    // device select bases
    localparam logic [7:0] DEVSEL_CHS = 8'hA0;
    localparam logic [7:0] DEVSEL_LBA = 8'hE0;

    // chs geometry
    localparam logic [6:0] SECTORS_PER_TRACK = 7'd63;

    localparam logic [47:0] RESET_THRESHOLD = 48'h0000_0010_0000;

endpackage

/* hw/rtl/atatf_chs_div.sv */
module atatf_chs_div
    import atatf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] lba,
    input  logic        ack,
    output logic        busy,
    output logic        done,
    output logic [7:0]  sector,
    output logic [3:0]  head,
    output logic [15:0] cylinder
);

    // inverse of 63 modulo 2**20; only 20 quotient bits are needed
    localparam logic [19:0] INV_SPT = 20'hBEFBF;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [8:0]  dsum_reg;
    logic [19:0] low_reg;
    logic [5:0]  rem_reg;
    logic [19:0] diff_reg;

    logic [8:0]  dsum;
    logic [6:0]  fold_a;
    logic [6:0]  fold_b;
    logic [5:0]  rem;
    logic [19:0] quo;

    // 64 is 1 mod 63, so the base-64 digit sum keeps the remainder
    always_comb
    begin
        dsum = '0;
        for (int i = 0; i < 8; i++)
            dsum = dsum + {3'b000, lba[6*i +: 6]};
    end

    assign fold_a = {4'b0000, dsum_reg[8:6]} + {1'b0, dsum_reg[5:0]};
    assign fold_b = {6'd0, fold_a[6]} + {1'b0, fold_a[5:0]};
    assign rem    = (fold_b == SECTORS_PER_TRACK) ? 6'd0 : fold_b[5:0];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
            busy_next = 1'b1;
        else if (busy_reg)
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
        else if (ack)
            done_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dsum_reg <= dsum;
            low_reg  <= lba[19:0];
        end
        if (busy_reg)
        begin
            rem_reg  <= rem;
            diff_reg <= low_reg - {14'd0, rem};
        end
    end

    // lba minus remainder is an exact multiple of 63
    assign quo      = diff_reg * INV_SPT;

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign sector   = {2'b00, rem_reg} + 8'd1;
    assign head     = quo[3:0];
    assign cylinder = quo[19:4];

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("chs divider done while still busy");

endmodule

/* hw/rtl/atatf_front.sv */
module atatf_front
    import atatf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  cmd_word_t   cmd_word,
    input  logic        q_full,
    output logic        push,
    output cmd_entry_t  push_entry
);

    logic        lba_sup_reg;
    logic        slave_reg;
    logic [47:0] thresh_reg;
    addr_mode_t  last_mode_reg, last_mode_next;
    logic [15:0] count_hold_reg;
    logic        write_hold_reg;

    logic        cmd_acc;
    logic        use_lba48;
    logic        is_chs;
    logic        div_busy, div_done, div_ack;
    logic [7:0]  div_sector;
    logic [3:0]  div_head;
    logic [15:0] div_cyl;
    cmd_entry_t  imm_entry, chs_entry;

    atatf_chs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd_acc && is_chs),
        .lba      (cmd_word.start_sector),
        .ack      (div_ack),
        .busy     (div_busy),
        .done     (div_done),
        .sector   (div_sector),
        .head     (div_head),
        .cylinder (div_cyl)
    );

    assign cmd_stall = div_busy || div_done || q_full;
    assign cmd_acc   = cmd_valid && !cmd_stall;
    assign use_lba48 = cmd_word.start_sector >= thresh_reg;
    assign is_chs    = !cmd_word.kind && !use_lba48 && !lba_sup_reg;
    assign div_ack   = div_done && !q_full;

    always_comb
    begin
        imm_entry = '0;
        if (cmd_word.kind)
        begin
            imm_entry.flush  = 1'b1;
            imm_entry.opcode = (last_mode_reg == MODE_LBA48) ? OP_FLUSH_EXT : OP_FLUSH;
        end
        else if (use_lba48)
        begin
            imm_entry.lba48     = 1'b1;
            imm_entry.devsel    = DEVSEL_LBA | {3'b000, slave_reg, 4'h0};
            imm_entry.count     = cmd_word.sector_count;
            imm_entry.lba_bytes = cmd_word.start_sector;
            imm_entry.opcode    = cmd_word.is_write ? OP_WRITE_EXT : OP_READ_EXT;
        end
        else
        begin
            imm_entry.devsel    = DEVSEL_LBA | {3'b000, slave_reg, 4'h0}
                                | {4'h0, cmd_word.start_sector[27:24]};
            imm_entry.count     = cmd_word.sector_count;
            imm_entry.lba_bytes = {24'h0, cmd_word.start_sector[23:0]};
            imm_entry.opcode    = cmd_word.is_write ? OP_WRITE : OP_READ;
        end
    end

    always_comb
    begin
        chs_entry           = '0;
        chs_entry.devsel    = DEVSEL_CHS | {3'b000, slave_reg, 4'h0} | {4'h0, div_head};
        chs_entry.count     = count_hold_reg;
        chs_entry.lba_bytes = {24'h0, div_cyl, div_sector};
        chs_entry.opcode    = write_hold_reg ? OP_WRITE : OP_READ;
    end

    assign push       = (cmd_acc && !is_chs) || div_ack;
    assign push_entry = div_ack ? chs_entry : imm_entry;

    always_comb
    begin
        last_mode_next = last_mode_reg;
        if (cmd_acc && !cmd_word.kind)
        begin
            if (use_lba48)
                last_mode_next = MODE_LBA48;
            else if (lba_sup_reg)
                last_mode_next = MODE_LBA28;
            else
                last_mode_next = MODE_CHS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lba_sup_reg   <= 1'b1;
            slave_reg     <= 1'b0;
            thresh_reg    <= RESET_THRESHOLD;
            last_mode_reg <= MODE_CHS;
        end
        else
        begin
            last_mode_reg <= last_mode_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LBA_SUPPORTED:   lba_sup_reg <= cfg_data[0];
                    CFG_DEVICE_SLAVE:    slave_reg   <= cfg_data[0];
                    CFG_LBA48_THRESHOLD: thresh_reg  <= cfg_data;
                    default:             ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_acc && is_chs)
        begin
            count_hold_reg <= cmd_word.sector_count;
            write_hold_reg <= cmd_word.is_write;
        end
    end

endmodule

/* hw/rtl/atatf_queue.sv */
module atatf_queue
    import atatf_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  cmd_entry_t push_entry,
    input  logic       pop,
    output logic       full,
    output logic       head_valid,
    output cmd_entry_t head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_entry_t    slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    assign full       = count_reg == FULL_CNT;
    assign head_valid = count_reg != '0;
    assign head       = slot_reg[rd_ptr_reg];

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("command queue overflow");

endmodule

/* hw/rtl/atatf_back.sv */
module atatf_back
    import atatf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  cmd_entry_t head,
    output logic       pop,
    output logic       tf_valid,
    input  logic       tf_stall,
    output tf_word_t   tf_word
);

    logic       started_reg, started_next;
    logic [3:0] sel_reg, sel_next;
    logic       out_valid_reg, out_valid_next;
    tf_word_t   out_word_reg;

    logic       load;
    logic [3:0] cur_sel;
    logic [7:0] cur_value;

    assign load    = head_valid && (!out_valid_reg || !tf_stall);
    assign cur_sel = started_reg ? sel_reg : (head.flush ? SEL_CMD : SEL_DEVSEL);
    assign pop     = load && (cur_sel == SEL_CMD);

    always_comb
    begin
        case (cur_sel)
            SEL_DEVSEL:   cur_value = head.devsel;
            SEL_COUNT_HI: cur_value = head.count[15:8];
            SEL_LBA3:     cur_value = head.lba_bytes[31:24];
            SEL_LBA4:     cur_value = head.lba_bytes[39:32];
            SEL_LBA5:     cur_value = head.lba_bytes[47:40];
            SEL_COUNT_LO: cur_value = head.count[7:0];
            SEL_LBA0:     cur_value = head.lba_bytes[7:0];
            SEL_LBA1:     cur_value = head.lba_bytes[15:8];
            SEL_LBA2:     cur_value = head.lba_bytes[23:16];
            SEL_CMD:      cur_value = head.opcode;
            default:      cur_value = 8'h00;
        endcase
    end

    always_comb
    begin
        started_next   = started_reg;
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg && tf_stall;
        if (load)
        begin
            out_valid_next = 1'b1;
            if (cur_sel == SEL_CMD)
            begin
                started_next = 1'b0;
            end
            else
            begin
                started_next = 1'b1;
                if (cur_sel == SEL_DEVSEL)
                    sel_next = head.lba48 ? SEL_COUNT_HI : SEL_COUNT_LO;
                else
                    sel_next = cur_sel + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            sel_reg       <= SEL_DEVSEL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            started_reg   <= started_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_word_reg.reg_select <= cur_sel;
            out_word_reg.reg_value  <= cur_value;
            out_word_reg.last       <= cur_sel == SEL_CMD;
        end
    end

    assign tf_valid = out_valid_reg;
    assign tf_word  = out_word_reg;

    a_last_on_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (tf_valid && tf_word.last) |-> tf_word.reg_select == SEL_CMD)
        else $error("last flag on a write other than the command");

    a_run_holds_head: assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |-> head_valid)
        else $error("write run in progress without a queued command");

endmodule

/* hw/rtl/ata_taskfile_command_issuer.sv */
// ata task-file command issuer: each request word (kind 0) becomes the ordered
// task-file register writes that start a pio read or write, one word per write
// on the tf channel, with last set on the opcode write; a flush word (kind 1)
// becomes a single opcode write, flush ext if the last command used lba48.
// addressing is lba48 for start sectors at or above lba48_threshold, lba28 when
// lba_supported is set, chs otherwise (16 heads, 63 sectors per track).
// the back end drives one write per cycle unless tf_stall holds it: lba48
// writes devsel, count hi, lba3-5, count lo, lba0-2, opcode; lba28 and chs
// skip count hi and lba3-5; a flush writes only the opcode. this sequencer
// sets the sustained rate. lba28, lba48 and flush words are decoded in the
// cycle they are taken; a chs word holds the input off while the divide-by-63
// unit (base-64 digit sum, then an exact multiply by the inverse of 63) works
// and until its result is pushed, overlapped with the back end draining older
// commands. the decoded-command queue lets the front take words meanwhile; no
// init sweep. configuration must be written while idle (the block won't check).
module ata_taskfile_command_issuer
    import atatf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration writes
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data,
    // request words
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  cmd_word_t   cmd_word,
    // task-file register write words
    output logic        tf_valid,
    input  logic        tf_stall,
    output tf_word_t    tf_word
);

    // front to queue
    logic       push;
    cmd_entry_t push_entry;
    logic       q_full;

    // queue to back
    logic       head_valid;
    cmd_entry_t head;
    logic       pop;

    // front: config regs, mode decision, chs divide, flush opcode choice
    atatf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd_word   (cmd_word),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // decoded commands waiting for the write sequencer
    atatf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head)
    );

    // back: steps through the register writes into the output register
    atatf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .tf_valid   (tf_valid),
        .tf_stall   (tf_stall),
        .tf_word    (tf_word)
    );

endmodule

/* dv/tb_top.sv */
module tb_top;
    import atatf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // request kinds and the one index with no register behind it
    localparam logic       KIND_CMD   = 1'b0;
    localparam logic       KIND_FLUSH = 1'b1;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    localparam logic [47:0] SECTOR_MAX = 48'hFFFF_FFFF_FFFF;

    // settle time after the last write of a phase; covers the chs divider
    // plus a full queue of decoded commands
    localparam int IDLE_CYCLES = 24;

    // generous cap: worst case is ~180 words x 10 writes x long stalls
    localparam int RUN_LIMIT_NS = 20_000_000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [47:0] cfg_data;
    logic        cmd_valid;
    logic        cmd_stall;
    cmd_word_t   cmd_word;
    logic        tf_valid;
    logic        tf_stall;
    tf_word_t    tf_word;

    ata_taskfile_command_issuer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .tf_valid  (tf_valid),
        .tf_stall  (tf_stall),
        .tf_word   (tf_word)
    );

    // shadow copy of the block's registers and remembered addressing mode
    logic        lba_ok;
    logic        slave_sel;
    logic [47:0] lba48_from;
    addr_mode_t  mode_seen;

    // task-file writes still owed by the block, oldest first
    tf_word_t    expected_writes[$];
    int          mismatches;

    // calm: no gaps and no stalls; hold_request: long sink stall in cycles
    bit          calm;
    int          hold_request;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    function automatic void push_write(logic [3:0] sel, logic [7:0] val, logic fin);
        tf_word_t w;
        w.reg_select = sel;
        w.reg_value  = val;
        w.last       = fin;
        expected_writes.push_back(w);
    endfunction

    // register writes that one accepted request word must produce
    function automatic void model_writes(cmd_word_t w);
        logic [47:0] ss;
        logic [47:0] track;
        logic [47:0] sec_in_track;
        logic [47:0] cyl_wide;
        logic [15:0] cyl;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [3:0]  head;
        logic [7:0]  devsel;
        logic [7:0]  op;
        addr_mode_t  mode;
        ss = w.start_sector;
        // flush only looks at the stored mode, state unchanged
        if (w.kind == KIND_FLUSH)
        begin
            push_write(SEL_CMD, (mode_seen == MODE_LBA48) ? OP_FLUSH_EXT : OP_FLUSH, 1'b1);
            return;
        end
        head = 4'd0;
        b0 = ss[7:0];
        b1 = ss[15:8];
        b2 = ss[23:16];
        if (ss >= lba48_from)
            mode = MODE_LBA48;
        else if (lba_ok)
        begin
            // bits above 27 are dropped, 27..24 go into devsel
            mode = MODE_LBA28;
            head = ss[27:24];
        end
        else
        begin
            // 63 sectors per track, 16 heads, cylinder wraps at 16 bits
            mode = MODE_CHS;
            track = ss / SECTORS_PER_TRACK;
            sec_in_track = ss % SECTORS_PER_TRACK;
            cyl_wide = track >> 4;
            cyl = cyl_wide[15:0];
            head = track[3:0];
            b0 = sec_in_track[7:0] + 8'd1;
            b1 = cyl[7:0];
            b2 = cyl[15:8];
        end
        devsel = (mode == MODE_CHS) ? DEVSEL_CHS : DEVSEL_LBA;
        devsel = devsel | {3'b000, slave_sel, head};
        push_write(SEL_DEVSEL, devsel, 1'b0);
        if (mode == MODE_LBA48)
        begin
            push_write(SEL_COUNT_HI, w.sector_count[15:8], 1'b0);
            push_write(SEL_LBA3, ss[31:24], 1'b0);
            push_write(SEL_LBA4, ss[39:32], 1'b0);
            push_write(SEL_LBA5, ss[47:40], 1'b0);
        end
        push_write(SEL_COUNT_LO, w.sector_count[7:0], 1'b0);
        push_write(SEL_LBA0, b0, 1'b0);
        push_write(SEL_LBA1, b1, 1'b0);
        push_write(SEL_LBA2, b2, 1'b0);
        if (w.is_write)
            op = (mode == MODE_LBA48) ? OP_WRITE_EXT : OP_WRITE;
        else
            op = (mode == MODE_LBA48) ? OP_READ_EXT : OP_READ;
        push_write(SEL_CMD, op, 1'b1);
        mode_seen = mode;
    endfunction

    // ------------------------------------------------------------------
    // monitor and checker: one process so an accepted request is always
    // predicted before any write in the same edge is checked
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : tf_check
        tf_word_t want;
        if (rst_n && cmd_valid && !cmd_stall)
            model_writes(cmd_word);
        if (rst_n && tf_valid && !tf_stall)
        begin
            if (expected_writes.size() == 0)
            begin
                mismatches++;
                $display("%0t: tf word expected none actual sel %0d val %02h last %0b",
                         $time, tf_word.reg_select, tf_word.reg_value, tf_word.last);
            end
            else
            begin
                want = expected_writes.pop_front();
                if (tf_word.reg_select !== want.reg_select)
                begin
                    mismatches++;
                    $display("%0t: reg_select expected %0d actual %0d", $time,
                             want.reg_select, tf_word.reg_select);
                end
                if (tf_word.reg_value !== want.reg_value)
                begin
                    mismatches++;
                    $display("%0t: reg_value (sel %0d) expected %02h actual %02h", $time,
                             want.reg_select, want.reg_value, tf_word.reg_value);
                end
                if (tf_word.last !== want.last)
                begin
                    mismatches++;
                    $display("%0t: last (sel %0d) expected %0b actual %0b", $time,
                             want.reg_select, want.last, tf_word.last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // pacing
    // ------------------------------------------------------------------

    // mostly short pauses, now and then a long one
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 8);
        else
            return $urandom_range(20, 40);
    endfunction

    // sink side: random stalls, plus a long hold when a test asks for one
    initial
    begin : tf_sink
        int stall_left;
        stall_left = 0;
        tf_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                stall_left = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0)
            begin
                tf_stall <= 1'b1;
                stall_left--;
            end
            else if (calm || $urandom_range(0, 99) < 60)
                tf_stall <= 1'b0;
            else
            begin
                tf_stall <= 1'b1;
                stall_left = pick_pause() - 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // offer one request word; returns right after the accepting edge.
    // valid stays up between back-to-back words so it never dips
    task automatic send_cmd(cmd_word_t w);
        int gap;
        gap = (calm || $urandom_range(0, 1) == 0) ? 0 : pick_pause();
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_word  <= w;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    // drop valid, wait for every owed write, then let the block settle
    task automatic wait_idle();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (expected_writes.size() != 0)
            @(negedge clk);
        repeat (IDLE_CYCLES) @(negedge clk);
    endtask

    // one register write; only called while idle
    task automatic write_reg(logic [1:0] idx, logic [47:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_LBA_SUPPORTED:   lba_ok = val[0];
            CFG_DEVICE_SLAVE:    slave_sel = val[0];
            CFG_LBA48_THRESHOLD: lba48_from = val;
            default: ;
        endcase
    endtask

    // rewrite all three registers; the 1-bit ones get junk in the upper bits
    task automatic set_config(logic lba, logic slave, logic [47:0] thr);
        logic [47:0] junk;
        junk[47:32] = 16'($urandom);
        junk[31:0]  = $urandom;
        write_reg(CFG_LBA_SUPPORTED, {junk[47:1], lba});
        write_reg(CFG_DEVICE_SLAVE, {junk[46:0], slave});
        write_reg(CFG_LBA48_THRESHOLD, thr);
    endtask

    function automatic cmd_word_t make_cmd(logic k, logic wr, logic [47:0] sec,
                                           logic [15:0] cnt);
        cmd_word_t w;
        w.kind         = k;
        w.is_write     = wr;
        w.start_sector = sec;
        w.sector_count = cnt;
        return w;
    endfunction

    function automatic logic [47:0] rand48();
        logic [47:0] v;
        v[47:32] = 16'($urandom);
        v[31:0]  = $urandom;
        return v;
    endfunction

    // random word, start sectors steered toward the interesting regions:
    // either side of the lba48 threshold, values within 28 bits, tiny chs values
    function automatic cmd_word_t rand_cmd();
        logic [47:0] sec;
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            sec = rand48();
        else if (r < 45)
            sec = lba48_from + 48'($signed($urandom_range(0, 8)) - 4);
        else if (r < 65)
            sec = {20'd0, 28'($urandom)};
        else if (r < 80)
            sec = 48'($urandom_range(0, 2000));
        else
            sec = rand48() >> $urandom_range(0, 40);
        return make_cmd(($urandom_range(0, 99) < 15) ? KIND_FLUSH : KIND_CMD,
                        1'($urandom), sec, 16'($urandom));
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset values: lba28 below 1 MiB sectors, lba48 at and above it;
    // flush before any command must use the chs (non-ext) opcode
    task automatic test_reset_modes_and_flush();
        send_cmd(make_cmd(KIND_FLUSH, 1'b1, SECTOR_MAX, 16'hFFFF));
        send_cmd(make_cmd(KIND_CMD, 1'b0, 48'd0, 16'h0000));
        send_cmd(make_cmd(KIND_CMD, 1'b1, 48'h0F_FFFF, 16'hFFFF));
        send_cmd(make_cmd(KIND_CMD, 1'b0, 48'h10_0000, 16'h0100));
        send_cmd(make_cmd(KIND_FLUSH, 1'b0, 48'd0, 16'h0000));
        send_cmd(make_cmd(KIND_CMD, 1'b1, SECTOR_MAX, 16'hFFFF));
        send_cmd(make_cmd(KIND_FLUSH, 1'b1, 48'd0, 16'h0000));
        send_cmd(make_cmd(KIND_CMD, 1'b0, 48'd5, 16'h00FF));
        send_cmd(make_cmd(KIND_FLUSH, 1'b0, 48'd0, 16'h0000));
        wait_idle();
    endtask

    // chs on a slave drive: track and cylinder edges, cylinder wrap
    task automatic test_chs_geometry();
        set_config(1'b0, 1'b1, SECTOR_MAX);
        send_cmd(make_cmd(KIND_CMD, 1'b0, 48'd0, 16'h0001));
        send_cmd(make_cmd(KIND_CMD, 1'b1, 48'd62, 16'h8000));
        send_cmd(make_cmd(KIND_CMD, 1'b0, 48'd63, 16'h0002));
        send_cmd(make_cmd(KIND_CMD, 1'b1, 48'd1007, 16'hFFFF));
        send_cmd(make_cmd(KIND_CMD, 1'b0, 48'd1008, 16'h1234));
        send_cmd(make_cmd(KIND_CMD, 1'b1, SECTOR_MAX - 48'd1, 16'hABCD));
        send_cmd(make_cmd(KIND_FLUSH, 1'b1, 48'd0, 16'h0000));
        wait_idle();
    endtask

    // lba28 drops high sector bits; zero threshold forces lba48 everywhere;
    // writes to the unused index must change nothing
    task automatic test_lba28_wrap_and_zero_threshold();
        set_config(1'b1, 1'b1, SECTOR_MAX);
        write_reg(CFG_UNUSED, rand48());
        send_cmd(make_cmd(KIND_CMD, 1'b0, SECTOR_MAX - 48'd1, 16'h00FF));
        send_cmd(make_cmd(KIND_CMD, 1'b1, 48'h0ABC_DEF1_2345, 16'h5A5A));
        wait_idle();
        write_reg(CFG_LBA48_THRESHOLD, 48'd0);
        write_reg(CFG_UNUSED, SECTOR_MAX);
        send_cmd(make_cmd(KIND_CMD, 1'b0, 48'd0, 16'h0000));
        send_cmd(make_cmd(KIND_FLUSH, 1'b0, 48'd0, 16'h0000));
        wait_idle();
    endtask

    // sink holds off for a long stretch while lba48 words keep coming,
    // so the decoded-command queue fills and the input stalls
    task automatic test_output_hold_off();
        int i;
        set_config(1'b1, 1'b0, 48'd0);
        @(posedge clk);
        hold_request = 150;
        for (i = 0; i < 10; i++)
            send_cmd(make_cmd(KIND_CMD, 1'($urandom), rand48(), 16'($urandom)));
        wait_idle();
    endtask

    // random traffic across register settings, extremes included
    task automatic test_random_phases();
        int phase;
        int i;
        logic [47:0] thr;
        for (phase = 0; phase < 6; phase++)
        begin
            calm = (phase == 0);
            case (phase)
                0: set_config(1'b1, 1'b0, RESET_THRESHOLD);
                1: set_config(1'b0, 1'b1, SECTOR_MAX);
                2: set_config(1'b1, 1'b1, 48'd1 << $urandom_range(20, 47));
                3: set_config(1'b0, 1'b0, rand48());
                4: set_config(1'b1, 1'b0, 48'd0);
                default:
                begin
                    thr = (48'd1 << $urandom_range(20, 40)) + 48'($urandom_range(0, 999));
                    set_config(1'b0, 1'b1, thr);
                end
            endcase
            for (i = 0; i < 25; i++)
                send_cmd(rand_cmd());
            wait_idle();
        end
        calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_LBA_SUPPORTED;
        cfg_data     = 48'd0;
        cmd_valid    = 1'b0;
        cmd_word     = '0;
        mismatches   = 0;
        calm         = 1'b0;
        hold_request = 0;
        // shadow state mirrors the block's reset values
        lba_ok       = 1'b1;
        slave_sel    = 1'b0;
        lba48_from   = RESET_THRESHOLD;
        mode_seen    = MODE_CHS;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        test_reset_modes_and_flush();
        test_chs_geometry();
        test_lba28_wrap_and_zero_threshold();
        test_output_hold_off();
        test_random_phases();

        wait_idle();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
